>>> sv/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// Shared constants for the sphere vertex generator: CORDIC tables, angle
// scaling and register map.
// ----------------------------------------------------------------------------
package svg_pkg;

	// Turn fractions are 32 bits; the dividers yield one more bit for 1.0
	localparam int TURN_BITS = 32;
	localparam int QUOT_BITS = TURN_BITS + 1;

	// CORDIC datapath width (Q2.30 plus headroom)
	localparam int CW = 34;

	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
	localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
	localparam logic [31:0] EIGHTH_TURN     = 32'h2000_0000;

	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
		32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
		32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
		32'd262143,    32'd131071,    32'd65535,     32'd32767,
		32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127
	};

	// Register map: byte address 4*i, index taken from paddr[2]
	localparam int ADDR_WIDTH = 3;
	localparam logic REG_STACK_COUNT = 1'b0;
	localparam logic REG_SLICE_COUNT = 1'b1;

endpackage

>>> sv/svg_divider.sv
// ----------------------------------------------------------------------------
// svg_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module svg_divider #(
	parameter int W = 10
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [W+svg_pkg::QUOT_BITS-1:0]      dividend,
	input  logic [W-1:0]                         divisor,
	output logic [svg_pkg::QUOT_BITS-1:0]        quotient
);
	localparam int QB = svg_pkg::QUOT_BITS;

	logic [W-1:0]  rem_s  [QB+1];
	logic [QB-1:0] work_s [QB+1];
	logic [W-1:0]  div_s  [QB+1];

	// Upper dividend bits are already below the divisor when the index is in range
	assign rem_s[0]  = dividend[W+QB-1:QB];
	assign work_s[0] = dividend[QB-1:0];
	assign div_s[0]  = divisor;

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [W:0] cat;
		logic [W:0] diff;
		logic       ge;
		assign cat  = {rem_s[i], work_s[i][QB-1]};
		assign diff = cat - {1'b0, div_s[i]};
		assign ge   = (cat >= {1'b0, div_s[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[W-1:0] : cat[W-1:0];
				work_s[i+1] <= {work_s[i][QB-2:0], ge};
				div_s[i+1]  <= div_s[i];
			end
		end
	end

	assign quotient = work_s[QB];

endmodule

>>> sv/svg_sincos.sv
// ----------------------------------------------------------------------------
// svg_sincos
// Quadrant fold, radian scaling and pipelined rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module svg_sincos #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        angle,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);
	localparam int CW = svg_pkg::CW;

	logic [1:0]         quad_s1;
	logic signed [31:0] rem_s1;
	logic [1:0]         quad_s2;
	logic signed [CW-1:0] z_s2;

	logic [31:0] biased;
	logic [1:0]  quad;
	logic [31:0] folded;
	logic signed [63:0] prod;

	assign biased = angle + svg_pkg::EIGHTH_TURN;
	assign quad   = biased[31:30];
	assign folded = angle - {quad, 30'd0};
	assign prod   = rem_s1 * $signed(svg_pkg::HALF_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad;
			rem_s1  <= $signed(folded);
			quad_s2 <= quad_s1;
			z_s2    <= CW'(prod >>> 30);
		end
	end

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [CW-1:0] z_s [STEPS+1];
	logic [1:0]           q_s [STEPS+1];

	assign x_s[0] = $signed({2'b00, svg_pkg::CORDIC_GAIN_Q30});
	assign y_s[0] = '0;
	assign z_s[0] = z_s2;
	assign q_s[0] = quad_s2;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign at = $signed({2'b00, svg_pkg::ATAN_Q30[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + at;
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	logic signed [CW-1:0] cx;
	logic signed [CW-1:0] sx;

	// Unfold the quadrant
	always_comb begin
		unique case (q_s[STEPS])
			2'd0: begin cx = x_s[STEPS];  sx = y_s[STEPS];  end
			2'd1: begin cx = -y_s[STEPS]; sx = x_s[STEPS];  end
			2'd2: begin cx = -x_s[STEPS]; sx = -y_s[STEPS]; end
			default: begin cx = y_s[STEPS]; sx = -x_s[STEPS]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= cx[31:0];
			sin_o <= sx[31:0];
		end
	end

endmodule

>>> sv/svg_delay.sv
// ----------------------------------------------------------------------------
// svg_delay
// Stallable shift line carrying side data alongside the pipeline.
// ----------------------------------------------------------------------------
module svg_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

>>> sv/sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// sphere_vertex_generator
// Unit UV-sphere vertex generator: position (Q1.15) and texture
// coordinates (Q1.16) for a stack/slice index pair.
// ----------------------------------------------------------------------------
// The block takes one vertex request per cycle while in_ready is high and
// returns exactly one vertex per request, in order. A request passes
// through one capture stage, 33 stages of the bit-per-stage dividers that
// form the angle and texture fractions, CORDIC_STEPS + 3 stages of the
// sine/cosine unit, one multiply stage, one rounding stage and the output
// register. Throughput is one vertex per cycle while no stall holds the
// pipeline. When the output register is full and not taken the pipeline
// still moves until its last stage holds a vertex; only then is in_ready
// dropped. An index above its count, or a count of zero, sets range_error
// with all other fields zero. Write the counts over APB only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module sphere_vertex_generator #(
	parameter int INDEX_WIDTH  = 10,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [svg_pkg::ADDR_WIDTH-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [INDEX_WIDTH-1:0]           stack_index,
	input  logic [INDEX_WIDTH-1:0]           slice_index,
	// vertex channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [15:0]               pos_x,
	output logic signed [15:0]               pos_y,
	output logic signed [15:0]               pos_z,
	output logic [16:0]                      tex_u,
	output logic [16:0]                      tex_v,
	output logic                             range_error
);
	localparam int W   = INDEX_WIDTH;
	localparam int QB  = svg_pkg::QUOT_BITS;
	localparam int DW  = W + QB;
	// Stages from capture to the rounding stage, inclusive
	localparam int NST = QB + CORDIC_STEPS + 6;
	localparam logic [W-1:0] STACK_RESET = W'(90);
	localparam logic [W-1:0] SLICE_RESET = W'(180);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [W-1:0] stack_count_q;
	logic [W-1:0] slice_count_q;
	logic         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q <= STACK_RESET;
			slice_count_q <= SLICE_RESET;
		end else if (cfg_wr) begin
			// keep only the low index bits of the written data
			unique case (paddr[2])
				svg_pkg::REG_STACK_COUNT: stack_count_q <= pwdata[W-1:0];
				default:                  slice_count_q <= pwdata[W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			svg_pkg::REG_STACK_COUNT: prdata = 32'(stack_count_q);
			default:                  prdata = 32'(slice_count_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: one enable for the whole pipeline. The output register
	// parts the two sides, so the pipeline moves whenever its last stage
	// is empty or can hand its vertex on.
	// ------------------------------------------------------------------
	logic           en;
	logic           xfer;
	logic           vld_s [NST];
	logic           out_valid_q;

	assign xfer     = ~out_valid_q | out_ready;
	assign en       = ~vld_s[NST-1] | xfer;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the request and the counts, check the range
	// ------------------------------------------------------------------
	logic [W-1:0] st_s1;
	logic [W-1:0] sl_s1;
	logic [W-1:0] ns_s1;
	logic [W-1:0] nl_s1;
	logic         err_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= stack_index;
			sl_s1  <= slice_index;
			ns_s1  <= stack_count_q;
			nl_s1  <= slice_count_q;
			err_s1 <= (stack_count_q == '0) | (slice_count_q == '0) |
			          (stack_index > stack_count_q) | (slice_index > slice_count_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: rounded fractions, index * 2^k / count, all over 33 steps
	// ------------------------------------------------------------------
	logic [DW-1:0] el_num, az_num, u_num, v_num;
	logic [QB-1:0] el_quo, az_quo, u_quo, v_quo;

	assign el_num = (DW'(st_s1) << 31) + DW'(ns_s1 >> 1);
	assign az_num = (DW'(sl_s1) << 32) + DW'(nl_s1 >> 1);
	assign v_num  = (DW'(st_s1) << 16) + DW'(ns_s1 >> 1);
	assign u_num  = (DW'(sl_s1) << 16) + DW'(nl_s1 >> 1);

	svg_divider #(.W(W)) u_div_el (
		.clk(clk), .en(en), .dividend(el_num), .divisor(ns_s1), .quotient(el_quo)
	);
	svg_divider #(.W(W)) u_div_az (
		.clk(clk), .en(en), .dividend(az_num), .divisor(nl_s1), .quotient(az_quo)
	);
	svg_divider #(.W(W)) u_div_v (
		.clk(clk), .en(en), .dividend(v_num), .divisor(ns_s1), .quotient(v_quo)
	);
	svg_divider #(.W(W)) u_div_u (
		.clk(clk), .en(en), .dividend(u_num), .divisor(nl_s1), .quotient(u_quo)
	);

	// ------------------------------------------------------------------
	// Stage 3: sine and cosine of elevation and azimuth
	// ------------------------------------------------------------------
	logic [31:0]        el_turn;
	logic signed [31:0] ce, se, ca, sa;

	// elevation = quarter turn - stack fraction of half a turn
	assign el_turn = svg_pkg::QUARTER_TURN - el_quo[31:0];

	svg_sincos #(.STEPS(CORDIC_STEPS)) u_sc_el (
		.clk(clk), .en(en), .angle(el_turn), .cos_o(ce), .sin_o(se)
	);
	svg_sincos #(.STEPS(CORDIC_STEPS)) u_sc_az (
		.clk(clk), .en(en), .angle(az_quo[31:0]), .cos_o(ca), .sin_o(sa)
	);

	// Side data travels alongside to the rounding stage
	logic [16:0] u_d, v_d;
	logic        err_d;

	svg_delay #(.WIDTH(34), .DEPTH(CORDIC_STEPS + 4)) u_dly_uv (
		.clk(clk), .en(en), .din({u_quo[16:0], v_quo[16:0]}), .dout({u_d, v_d})
	);
	svg_delay #(.WIDTH(1), .DEPTH(NST - 2)) u_dly_err (
		.clk(clk), .en(en), .din(err_s1), .dout(err_d)
	);

	// ------------------------------------------------------------------
	// Stage 4: ring radius times azimuth, floored back to Q30
	// ------------------------------------------------------------------
	logic signed [63:0]  px_full, pz_full;
	logic signed [33:0]  px_s4, py_s4, pz_s4;

	assign px_full = ce * ca;
	assign pz_full = ce * sa;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4 <= 34'(px_full >>> 30);
			pz_s4 <= 34'(pz_full >>> 30);
			py_s4 <= 34'(se);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: round to Q1.15 with saturation, blank on a range error
	// ------------------------------------------------------------------
	function automatic logic [15:0] to_q15(input logic signed [33:0] v);
		logic signed [33:0] biased;
		logic signed [18:0] r;
		biased = v + 34'sd16384;
		r = 19'(biased >>> 15);
		if (r > 19'sd32767) begin
			return 16'h7FFF;
		end else if (r < -19'sd32768) begin
			return 16'h8000;
		end
		return r[15:0];
	endfunction

	logic [15:0] x_s5, y_s5, z_s5;
	logic [16:0] u_s5, v_s5;
	logic        err_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			err_s5 <= err_d;
			x_s5   <= err_d ? '0 : to_q15(px_s4);
			y_s5   <= err_d ? '0 : to_q15(py_s4);
			z_s5   <= err_d ? '0 : to_q15(pz_s4);
			u_s5   <= err_d ? '0 : u_d;
			v_s5   <= err_d ? '0 : v_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the vertex until the transaction completes
	// ------------------------------------------------------------------
	logic [15:0] x_q, y_q, z_q;
	logic [16:0] u_q, v_q;
	logic        err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && vld_s[NST-1]) begin
			x_q   <= x_s5;
			y_q   <= y_s5;
			z_q   <= z_s5;
			u_q   <= u_s5;
			v_q   <= v_s5;
			err_q <= err_s5;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = $signed(x_q);
	assign pos_y       = $signed(y_q);
	assign pos_z       = $signed(z_q);
	assign tex_u       = u_q;
	assign tex_v       = v_q;
	assign range_error = err_q;

`ifndef SYNTHESIS
	// A range error blanks every coordinate
	a_err_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |->
			pos_x == 16'sd0 && pos_y == 16'sd0 && pos_z == 16'sd0 &&
			tex_u == 17'd0 && tex_v == 17'd0)
		else $error("range error vertex not blanked");

	// Texture coordinates never exceed 1.0
	a_tex_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u <= 17'h10000 && tex_v <= 17'h10000)
		else $error("texture coordinate above 1.0");

	// Requests are refused only when both the last stage and the output are full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && vld_s[NST-1])
		else $error("input stalled without a full output");
`endif

endmodule
